// ===== sv/dapid_pkg.sv =====
package dapid_pkg;

  localparam int ANGLE_W   = 15;
  localparam int ERR_W     = ANGLE_W + 1;
  localparam int DERR_W    = ERR_W + 1;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 31;
  localparam int DT_W      = 16;
  localparam int THR_W     = 10;
  localparam int OUT_W     = 32;
  localparam int INTEG_W   = 48;
  localparam int CAND_W    = INTEG_W + 1;
  localparam int DRIVE_W   = 57;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  // shared multiplier operands and product
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // integral term: i_gain * integral / 2^24, integral split at this bit
  localparam int I_SHIFT = 24;

  // 4000000 = 15625 * 2^8 and 2^26 / 1000000 = 2^20 / 15625
  localparam int US_DIV  = 15625;
  localparam int D_SHIFT = 8;
  localparam int E_SHIFT = 20;

  // shared divider
  localparam int DIV_W              = 56;
  localparam int DEN_W              = DT_W;
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES         = DIV_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam logic AXIS_ROLL  = 1'b0;
  localparam logic AXIS_PITCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_P,
    REG_ROLL_I,
    REG_ROLL_D,
    REG_ROLL_LIMIT,
    REG_PITCH_P,
    REG_PITCH_I,
    REG_PITCH_D,
    REG_PITCH_LIMIT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_IH,
    ST_MUL_IL,
    ST_MUL_D,
    ST_MUL_DK,
    ST_DIV_D_GO,
    ST_DIV_D_WAIT,
    ST_ADD_D,
    ST_DIV_E_GO,
    ST_DIV_E_WAIT,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/dual_axis_pid_conditional_integral_unit.sv =====
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    target/measured roll and pitch, elapsed_us, armed,
//                                    airborne, throttle
// out      out  out_valid/out_ready  roll_drive, pitch_drive
// cfg      in   cfg_we               cfg_index, cfg_data
//
// a zero elapsed_us skips both derivative divisions
// each axis runs six products on one shared 33x25 multiplier and two divisions
// on one shared divider that retires 4 quotient bits per cycle
// reset is synchronous and clears gains, limits, previous errors and integrals
// in_ready is high only while idle; a result stalled by out_ready holds the last step
module dual_axis_pid_conditional_integral_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dapid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dapid_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dapid_pkg::ANGLE_W-1:0]   target_roll,
  input  logic signed [dapid_pkg::ANGLE_W-1:0]   target_pitch,
  input  logic signed [dapid_pkg::ANGLE_W-1:0]   measured_roll,
  input  logic signed [dapid_pkg::ANGLE_W-1:0]   measured_pitch,
  input  logic [dapid_pkg::DT_W-1:0]             elapsed_us,
  input  logic                                   armed,
  input  logic                                   airborne,
  input  logic [dapid_pkg::THR_W-1:0]            throttle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dapid_pkg::OUT_W-1:0]     roll_drive,
  output logic signed [dapid_pkg::OUT_W-1:0]     pitch_drive
);
  import dapid_pkg::*;

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0]  p_gain [2];
  logic [GAIN_W-1:0]  i_gain [2];
  logic [GAIN_W-1:0]  d_gain [2];
  logic [LIMIT_W-1:0] limit  [2];

  logic signed [ERR_W-1:0]   prev_err [2];
  logic signed [INTEG_W-1:0] integ    [2];
  logic signed [ERR_W-1:0]   err      [2];
  logic signed [DERR_W-1:0]  derr     [2];
  logic signed [OUT_W-1:0]   res      [2];

  logic [DT_W-1:0]  dt;
  logic             hold;
  logic [THR_W-1:0] thr;
  logic             axis;
  logic             d_neg;
  logic             e_neg;

  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_abs;
  logic signed [DRIVE_W-1:0] drive;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  logic                      accept;
  logic                      out_load;
  logic signed [ERR_W-1:0]   err_roll_in;
  logic signed [ERR_W-1:0]   err_pitch_in;
  logic signed [ERR_W-1:0]   e_sel;
  logic signed [INTEG_W-1:0] integ_sel;
  logic [LIMIT_W-1:0]        lim_sel;

  logic signed [DRIVE_W-1:0] i_low_term;
  logic                      i_round;
  logic signed [DRIVE_W-1:0] d_term;
  logic signed [CAND_W-1:0]  delta;
  logic signed [CAND_W-1:0]  cand;
  logic signed [CAND_W-1:0]  lim_q;
  logic signed [DRIVE_W-1:0] lim_d;
  logic signed [DRIVE_W-1:0] thr_d;
  logic                      integ_ok;
  logic signed [OUT_W-1:0]   sat;

  dapid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  assign err_roll_in  = ERR_W'(target_roll) - ERR_W'(measured_roll);
  assign err_pitch_in = ERR_W'(target_pitch) - ERR_W'(measured_pitch);

  assign e_sel     = err[axis];
  assign integ_sel = integ[axis];
  assign lim_sel   = limit[axis];
  assign prod_abs  = prod[PROD_W-1] ? -prod : prod;

  // term arithmetic
  always_comb begin
    i_low_term = DRIVE_W'({1'b0, prod[I_SHIFT+GAIN_W-1:I_SHIFT]});
    i_round    = integ_sel[INTEG_W-1] && (prod[I_SHIFT-1:0] != '0);
    if (dt == '0) begin
      d_term = '0;
    end else if (d_neg) begin
      d_term = -DRIVE_W'(div_rsp.quotient);
    end else begin
      d_term = DRIVE_W'(div_rsp.quotient);
    end
    delta    = e_neg ? -CAND_W'(div_rsp.quotient) : CAND_W'(div_rsp.quotient);
    cand     = CAND_W'(integ_sel) + delta;
    lim_q    = CAND_W'({lim_sel, {FRAC_W{1'b0}}});
    lim_d    = DRIVE_W'(lim_sel);
    thr_d    = DRIVE_W'({thr, {FRAC_W{1'b0}}});
    integ_ok = (drive < thr_d) && (drive > -thr_d)
            && (cand < lim_q) && (cand > -lim_q)
            && (drive < lim_d) && (drive > -lim_d);
    if ((&drive[DRIVE_W-1:OUT_W-1]) || !(|drive[DRIVE_W-1:OUT_W-1])) begin
      sat = drive[OUT_W-1:0];
    end else if (drive[DRIVE_W-1]) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_valid) state_next = ST_MUL_P;
      ST_MUL_P:      state_next = ST_MUL_IH;
      ST_MUL_IH:     state_next = ST_MUL_IL;
      ST_MUL_IL:     state_next = ST_MUL_D;
      ST_MUL_D:      state_next = ST_MUL_DK;
      ST_MUL_DK:     state_next = ST_DIV_D_GO;
      ST_DIV_D_GO:   state_next = (dt == '0) ? ST_ADD_D : ST_DIV_D_WAIT;
      ST_DIV_D_WAIT: if (div_rsp.done) state_next = ST_ADD_D;
      ST_ADD_D:      state_next = ST_DIV_E_GO;
      ST_DIV_E_GO:   state_next = ST_DIV_E_WAIT;
      ST_DIV_E_WAIT: if (div_rsp.done) state_next = ST_UPD;
      ST_UPD:        state_next = (axis == AXIS_PITCH) ? ST_FIN : ST_MUL_P;
      ST_FIN:        if (out_load) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // multiplier and divider control
  always_comb begin
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    unique case (state)
      ST_MUL_P: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(e_sel);
        mul_b  = $signed(MUL_B_W'(p_gain[axis]));
      end
      ST_MUL_IH: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(i_gain[axis]));
        mul_b  = MUL_B_W'($signed(integ_sel[INTEG_W-1:I_SHIFT]));
      end
      ST_MUL_IL: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(i_gain[axis]));
        mul_b  = $signed(MUL_B_W'(integ_sel[I_SHIFT-1:0]));
      end
      ST_MUL_D: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(derr[axis]);
        mul_b  = $signed(MUL_B_W'(d_gain[axis]));
      end
      ST_MUL_DK: begin
        mul_en = 1'b1;
        mul_a  = $signed(prod_abs[MUL_A_W-1:0]);
        mul_b  = MUL_B_W'(US_DIV);
      end
      ST_DIV_D_GO: begin
        mul_en           = 1'b1;
        mul_a            = MUL_A_W'(e_sel);
        mul_b            = $signed(MUL_B_W'(dt));
        div_req.start    = (dt != '0);
        div_req.dividend = {prod_abs[DIV_W-D_SHIFT-1:0], {D_SHIFT{1'b0}}};
        div_req.divisor  = dt;
      end
      ST_DIV_E_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod_abs[DIV_W-E_SHIFT-1:0], {E_SHIFT{1'b0}}};
        div_req.divisor  = DEN_W'(US_DIV);
      end
      ST_IDLE, ST_DIV_D_WAIT, ST_ADD_D, ST_DIV_E_WAIT, ST_UPD, ST_FIN: begin
        mul_en = 1'b0;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 2; a++) begin
        p_gain[a]   <= '0;
        i_gain[a]   <= '0;
        d_gain[a]   <= '0;
        limit[a]    <= '0;
        prev_err[a] <= '0;
        integ[a]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ROLL_P:      p_gain[AXIS_ROLL]  <= cfg_data[GAIN_W-1:0];
          REG_ROLL_I:      i_gain[AXIS_ROLL]  <= cfg_data[GAIN_W-1:0];
          REG_ROLL_D:      d_gain[AXIS_ROLL]  <= cfg_data[GAIN_W-1:0];
          REG_ROLL_LIMIT:  limit[AXIS_ROLL]   <= cfg_data[LIMIT_W-1:0];
          REG_PITCH_P:     p_gain[AXIS_PITCH] <= cfg_data[GAIN_W-1:0];
          REG_PITCH_I:     i_gain[AXIS_PITCH] <= cfg_data[GAIN_W-1:0];
          REG_PITCH_D:     d_gain[AXIS_PITCH] <= cfg_data[GAIN_W-1:0];
          REG_PITCH_LIMIT: limit[AXIS_PITCH]  <= cfg_data[LIMIT_W-1:0];
          default:         p_gain[AXIS_ROLL]  <= p_gain[AXIS_ROLL];
        endcase
      end
      if (state == ST_UPD) begin
        prev_err[axis] <= e_sel;
        if (!hold) begin
          integ[axis] <= '0;
        end else if (integ_ok) begin
          integ[axis] <= cand[INTEG_W-1:0];
        end
      end
    end
  end

  // beat capture and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      err[AXIS_ROLL]   <= err_roll_in;
      err[AXIS_PITCH]  <= err_pitch_in;
      derr[AXIS_ROLL]  <= DERR_W'(err_roll_in) - DERR_W'(prev_err[AXIS_ROLL]);
      derr[AXIS_PITCH] <= DERR_W'(err_pitch_in) - DERR_W'(prev_err[AXIS_PITCH]);
      dt               <= elapsed_us;
      hold             <= armed && airborne;
      thr              <= throttle;
    end
    if (mul_en) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
    case (state)
      ST_MUL_IH:   drive <= DRIVE_W'(prod <<< 2);
      ST_MUL_IL:   drive <= drive + DRIVE_W'(prod);
      ST_MUL_D:    drive <= drive + i_low_term + DRIVE_W'(i_round);
      ST_MUL_DK:   d_neg <= prod[PROD_W-1];
      ST_ADD_D:    drive <= drive + d_term;
      ST_DIV_E_GO: e_neg <= prod[PROD_W-1];
      ST_UPD:      res[axis] <= sat;
      default:     drive <= drive;
    endcase
    if (out_load) begin
      roll_drive  <= res[AXIS_ROLL];
      pitch_drive <= res[AXIS_PITCH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= AXIS_ROLL;
    end else if (accept) begin
      axis <= AXIS_ROLL;
    end else if (state == ST_UPD) begin
      axis <= AXIS_PITCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while a beat is in progress");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside the final step");

  a_div_free_on_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_D_WAIT || state == ST_DIV_E_WAIT))
    else $error("division finished outside a wait step");

  a_clear_when_grounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !hold) |=> (integ[$past(axis)] == '0))
    else $error("integral not cleared while disarmed or grounded");
`endif

endmodule

// ===== sv/dapid_div.sv =====
module dapid_div (
  input  logic                clk,
  input  logic                rst,
  input  dapid_pkg::div_req_t req,
  output dapid_pkg::div_rsp_t rsp
);
  import dapid_pkg::*;

  logic [DIV_W-1:0]     num;
  logic [DIV_W-1:0]     num_next;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     rem_next;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       trial;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  // restoring division, several quotient bits per cycle
  always_comb begin
    num_next = num;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      trial    = {rem_next, num_next[DIV_W-1]};
      num_next = {num_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial       = trial - {1'b0, den};
        num_next[0] = 1'b1;
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_CYCLES - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  always_comb begin
    rsp.busy     = busy;
    rsp.done     = busy && (cnt == '0);
    rsp.quotient = num;
  end

endmodule
